// ----- rtl/core/isort_pkg.sv -----
// Shared types and constants for the insertion sorter.
`default_nettype none

package isort_pkg;

    localparam int VALUE_W          = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_result;
        logic                      overflow;
    } out_item_t;

    // What one cell shows to its upper neighbor.
    typedef struct packed {
        logic                      occupied;
        logic                      greater;
        logic signed [VALUE_W-1:0] value;
    } cell_link_t;

endpackage

`default_nettype wire

// ----- rtl/core/isort_cell.sv -----
// One cell of the sorting chain: holds one entry and trades it with its neighbors.
`default_nettype none

module isort_cell
    import isort_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic signed [VALUE_W-1:0] ins_value,
    input  wire logic                      ins_en,
    input  wire logic                      shift_en,
    input  wire logic                      occupied,
    input  wire cell_link_t                prev_link,
    input  wire logic signed [VALUE_W-1:0] next_value,
    output cell_link_t                     link
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      greater;
    logic                      take;

    // Entries strictly greater than the new value move up one place, so equal
    // values keep their arrival order.
    assign greater = occupied && (value_reg > ins_value);
    // The first free cell above all smaller-or-equal entries also takes part.
    assign take    = greater || (!occupied && prev_link.occupied);

    always_comb begin
        value_next = value_reg;
        if (shift_en) begin
            value_next = next_value;
        end else if (ins_en && take) begin
            value_next = prev_link.greater ? prev_link.value : ins_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign link = '{occupied: occupied, greater: greater, value: value_reg};

endmodule

`default_nettype wire

// ----- rtl/core/insertion_sorter_top.sv -----
// Top level of the insertion sorter: a chain of sorting cells with fill and drain control.
//
// Usage: values arrive on the s_ channel, one per transaction, with last_item
// marking the end of a list. Each accepted value that finds room is placed
// into the chain of MAX_ELEMENTS cells; all cells compare the value at once and the
// larger entries step one cell up. Filling runs at one transaction per cycle.
// After the transaction marked last, s_ready drops and the chain is drained
// from its lowest cell on the m_ channel in ascending signed order, one
// transaction per cycle while m_ready is high; last_result marks the final
// result and overflow is set on every result of a list that lost values to a
// full chain. The first result is offered the cycle after the last input, and
// each accepted result shifts the chain one entry toward the output. When
// the receiver stalls, the head entry stays on m_item and the chain holds
// still. After the final result the block takes input again. Reset
// (aresetn low at a clock edge) empties the chain and clears the overflow flag;
// the cell contents need no reset.
`default_nettype none

module insertion_sorter_top
    import isort_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_item_t s_item,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_item
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;

    logic s_fire;
    logic m_fire;
    logic full;
    logic ins_en;

    cell_link_t links [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] occupied;

    assign s_ready = (state_reg == ST_FILL);
    assign m_valid = (state_reg == ST_DRAIN);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign full    = (count_reg == CNT_W'(MAX_ELEMENTS));
    assign ins_en  = s_fire && !full;

    // The chain's occupied cells are always a prefix, so the count says which.
    always_comb begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            occupied[i] = (CNT_W'(i) < count_reg);
        end
    end

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        cell_link_t               prev_link;
        logic signed [VALUE_W-1:0] next_value;

        if (g == 0) begin : g_bottom
            assign prev_link = '{occupied: 1'b1, greater: 1'b0, value: '0};
        end else begin : g_mid
            assign prev_link = links[g-1];
        end

        if (g == MAX_ELEMENTS - 1) begin : g_top
            assign next_value = '0;
        end else begin : g_below
            assign next_value = links[g+1].value;
        end

        isort_cell u_cell (
            .aclk       (aclk),
            .ins_value  (s_item.value),
            .ins_en     (ins_en),
            .shift_en   (m_fire),
            .occupied   (occupied[g]),
            .prev_link  (prev_link),
            .next_value (next_value),
            .link       (links[g])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_FILL: begin
                if (s_fire) begin
                    if (full) begin
                        overflow_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_item.last_item) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (m_fire) begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        state_next    = ST_FILL;
                        overflow_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next    = ST_FILL;
                count_next    = '0;
                overflow_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // The head of the chain is the smallest remaining entry.
    assign m_item = '{
        sorted_value: links[0].value,
        last_result:  (count_reg == CNT_W'(1)),
        overflow:     overflow_reg
    };

endmodule

`default_nettype wire
